[rtl/core/ac_pkg.sv]
// ----------------------------------------------------------------------------
// Aho-Corasick counter package
// Shared item kinds, controller commands, control structs and helpers.
// ----------------------------------------------------------------------------
package ac_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SCAN   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef logic [4:0] op_t;

  localparam op_t OP_IDLE     = 5'd0;
  localparam op_t OP_CLR      = 5'd1;
  localparam op_t OP_CHECK    = 5'd2;
  localparam op_t OP_PHASE    = 5'd3;
  localparam op_t OP_STEP_RD  = 5'd4;
  localparam op_t OP_STEP_USE = 5'd5;
  localparam op_t OP_SCAN_WR  = 5'd6;
  localparam op_t OP_RESP     = 5'd7;
  localparam op_t OP_B_R0     = 5'd8;
  localparam op_t OP_B_R0U    = 5'd9;
  localparam op_t OP_B_POP    = 5'd10;
  localparam op_t OP_B_NOW    = 5'd11;
  localparam op_t OP_B_FNOW   = 5'd12;
  localparam op_t OP_B_RCH    = 5'd13;
  localparam op_t OP_B_RVIA   = 5'd14;
  localparam op_t OP_B_USE    = 5'd15;
  localparam op_t OP_P_DEG_RD = 5'd16;
  localparam op_t OP_P_DEG_F  = 5'd17;
  localparam op_t OP_P_DEG_W  = 5'd18;
  localparam op_t OP_P_Z_RD   = 5'd19;
  localparam op_t OP_P_Z_U    = 5'd20;
  localparam op_t OP_P_POP    = 5'd21;
  localparam op_t OP_P_U      = 5'd22;
  localparam op_t OP_P_V      = 5'd23;
  localparam op_t OP_P_UPD    = 5'd24;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic later;
    logic is_insert;
    logic is_scan;
    logic kind_query;
    logic last;
    logic qempty;
    logic c_last;
    logic i_over;
    logic clr_done;
    logic out_free;
  } status_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[rtl/core/aho_corasick_occurrence_counter.sv]
// ----------------------------------------------------------------------------
// Aho-Corasick occurrence counter
// Multi-pattern trie, failure-link automaton and per-node hit counter.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the goto table and accepts
// no word until it ends. An insert or query word then passes the check, goto
// read and step states, plus the response state with any wait for out_ready
// when it answers on a last letter; a scan word adds a hit-count write, so it
// is bounded by the dependent goto-table read from the current state plus the
// hit-count read-modify-write. The first scan word runs the failure-link
// build, and the first query word runs count propagation (after the build if
// no scan word came first); input stalls meanwhile.
module aho_corasick_occurrence_counter #(
  parameter int MAX_NODES = 1024,
  parameter int ALPHABET  = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_letter,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_match_count,
  output logic        out_trie_full
);

  ac_pkg::cmd_t    cmd;
  ac_pkg::status_t st;

  assign in_ready = cmd.op == ac_pkg::OP_IDLE;

  ac_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .st(st), .cmd(cmd)
  );

  ac_dp #(.MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_valid(in_valid), .in_kind(in_kind), .in_letter(in_letter),
    .in_last(in_last), .out_valid(out_valid), .out_ready(out_ready),
    .out_match_count(out_match_count), .out_trie_full(out_trie_full)
  );

endmodule

[rtl/core/ac_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enable-held read.
// ----------------------------------------------------------------------------
module ac_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ac_ctrl.sv]
// ----------------------------------------------------------------------------
// Aho-Corasick controller
// Sequences clearing, item steps, link build and count propagation.
// ----------------------------------------------------------------------------
module ac_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  ac_pkg::status_t st,
  output ac_pkg::cmd_t    cmd
);

  localparam logic [4:0] S_IDLE     = ac_pkg::OP_IDLE;
  localparam logic [4:0] S_CLR      = ac_pkg::OP_CLR;
  localparam logic [4:0] S_CHECK    = ac_pkg::OP_CHECK;
  localparam logic [4:0] S_PHASE    = ac_pkg::OP_PHASE;
  localparam logic [4:0] S_STEP_RD  = ac_pkg::OP_STEP_RD;
  localparam logic [4:0] S_STEP_USE = ac_pkg::OP_STEP_USE;
  localparam logic [4:0] S_SCAN_WR  = ac_pkg::OP_SCAN_WR;
  localparam logic [4:0] S_RESP     = ac_pkg::OP_RESP;
  localparam logic [4:0] S_B_R0     = ac_pkg::OP_B_R0;
  localparam logic [4:0] S_B_R0U    = ac_pkg::OP_B_R0U;
  localparam logic [4:0] S_B_POP    = ac_pkg::OP_B_POP;
  localparam logic [4:0] S_B_NOW    = ac_pkg::OP_B_NOW;
  localparam logic [4:0] S_B_FNOW   = ac_pkg::OP_B_FNOW;
  localparam logic [4:0] S_B_RCH    = ac_pkg::OP_B_RCH;
  localparam logic [4:0] S_B_RVIA   = ac_pkg::OP_B_RVIA;
  localparam logic [4:0] S_B_USE    = ac_pkg::OP_B_USE;
  localparam logic [4:0] S_P_DEG_RD = ac_pkg::OP_P_DEG_RD;
  localparam logic [4:0] S_P_DEG_F  = ac_pkg::OP_P_DEG_F;
  localparam logic [4:0] S_P_DEG_W  = ac_pkg::OP_P_DEG_W;
  localparam logic [4:0] S_P_Z_RD   = ac_pkg::OP_P_Z_RD;
  localparam logic [4:0] S_P_Z_U    = ac_pkg::OP_P_Z_U;
  localparam logic [4:0] S_P_POP    = ac_pkg::OP_P_POP;
  localparam logic [4:0] S_P_U      = ac_pkg::OP_P_U;
  localparam logic [4:0] S_P_V      = ac_pkg::OP_P_V;
  localparam logic [4:0] S_P_UPD    = ac_pkg::OP_P_UPD;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:      if (st.clr_done) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (st.ignore) state_nxt = S_IDLE;
        else if (st.later) state_nxt = st.is_insert ? S_B_R0 : S_P_DEG_RD;
        else state_nxt = S_STEP_RD;
      end
      S_PHASE:    state_nxt = S_STEP_RD;
      S_STEP_RD:  state_nxt = S_STEP_USE;
      S_STEP_USE: begin
        if (st.is_scan) state_nxt = S_SCAN_WR;
        else if (st.last) state_nxt = S_RESP;
        else state_nxt = S_IDLE;
      end
      S_SCAN_WR:  state_nxt = S_IDLE;
      S_RESP:     if (st.out_free) state_nxt = S_IDLE;
      S_B_R0:     state_nxt = S_B_R0U;
      S_B_R0U:    state_nxt = st.c_last ? S_B_POP : S_B_R0;
      S_B_POP: begin
        if (!st.qempty) state_nxt = S_B_NOW;
        else state_nxt = st.kind_query ? S_P_DEG_RD : S_PHASE;
      end
      S_B_NOW:    state_nxt = S_B_FNOW;
      S_B_FNOW:   state_nxt = S_B_RCH;
      S_B_RCH:    state_nxt = S_B_RVIA;
      S_B_RVIA:   state_nxt = S_B_USE;
      S_B_USE:    state_nxt = st.c_last ? S_B_POP : S_B_RCH;
      S_P_DEG_RD: state_nxt = st.i_over ? S_P_Z_RD : S_P_DEG_F;
      S_P_DEG_F:  state_nxt = S_P_DEG_W;
      S_P_DEG_W:  state_nxt = S_P_DEG_RD;
      S_P_Z_RD:   state_nxt = st.i_over ? S_P_POP : S_P_Z_U;
      S_P_Z_U:    state_nxt = S_P_Z_RD;
      S_P_POP:    state_nxt = st.qempty ? S_PHASE : S_P_U;
      S_P_U:      state_nxt = S_P_V;
      S_P_V:      state_nxt = S_P_UPD;
      S_P_UPD:    state_nxt = S_P_POP;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.op = state_r;

endmodule

[rtl/core/ac_dp.sv]
// ----------------------------------------------------------------------------
// Aho-Corasick datapath
// Holds the automaton stores, queue pointers, cursor and output word.
// ----------------------------------------------------------------------------
module ac_dp #(
  parameter int MAX_NODES = 1024,
  parameter int ALPHABET  = 26
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ac_pkg::cmd_t    cmd,
  output ac_pkg::status_t st,
  input  logic            in_valid,
  input  logic [1:0]      in_kind,
  input  logic [4:0]      in_letter,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_match_count,
  output logic            out_trie_full
);

  localparam int NODES = MAX_NODES + 1;
  localparam int GD    = NODES * ALPHABET;
  localparam int GW    = $clog2(GD);
  localparam int NW    = $clog2(NODES);
  localparam int QW    = $clog2(NODES + 1);
  localparam int CW    = $clog2(ALPHABET);

  function automatic logic [GW-1:0] gidx(input logic [NW-1:0] row, input logic [CW-1:0] col);
    return GW'(row) * GW'(ALPHABET) + GW'(col);
  endfunction

  logic [1:0]    kind_r, kind_nxt;
  logic [4:0]    letter_r, letter_nxt;
  logic          last_r, last_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [NW-1:0] cursor_r, cursor_nxt;
  logic [NW-1:0] node_total_r, node_total_nxt;
  logic          ovf_r, ovf_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [QW-1:0] i_r, i_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [NW-1:0] now_r, now_nxt, fnow_r, fnow_nxt, ch_r, ch_nxt;
  logic [NW-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [31:0]   hu_r, hu_nxt;
  logic [GW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_cnt_r, out_cnt_nxt;
  logic          out_full_r, out_full_nxt;

  logic          gt_we, gt_re;
  logic [GW-1:0] gt_waddr, gt_raddr;
  logic [NW-1:0] gt_wdata, gt_rdata;
  logic          fl_we, fl_re, dg_we, dg_re, hc_we, hc_re, wq_we, wq_re;
  logic [NW-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;
  logic [NW-1:0] dg_waddr, dg_raddr, dg_wdata, dg_rdata;
  logic [NW-1:0] hc_waddr, hc_raddr;
  logic [31:0]   hc_wdata, hc_rdata;
  logic [NW-1:0] wq_waddr, wq_raddr, wq_wdata, wq_rdata;

  logic [GW-1:0] step_idx;
  logic          can_push;
  logic [NW-1:0] dnew;

  assign step_idx = gidx(cursor_r, letter_r[CW-1:0]);
  assign can_push = tail_r < QW'(NODES);
  assign dnew     = (dg_rdata != '0) ? dg_rdata - 1'b1 : '0;

  assign st.ignore     = (kind_r > ac_pkg::KIND_QUERY) || (kind_r < phase_r) ||
                         (32'(letter_r) >= ALPHABET);
  assign st.later      = kind_r > phase_r;
  assign st.is_insert  = phase_r == ac_pkg::KIND_INSERT;
  assign st.is_scan    = phase_r == ac_pkg::KIND_SCAN;
  assign st.kind_query = kind_r == ac_pkg::KIND_QUERY;
  assign st.last       = last_r;
  assign st.qempty     = head_r == tail_r;
  assign st.c_last     = c_r == CW'(ALPHABET - 1);
  assign st.i_over     = i_r > QW'(node_total_r);
  assign st.clr_done   = clr_r == GW'(GD - 1);
  assign st.out_free   = !out_valid_r || out_ready;

  always_comb begin
    kind_nxt = kind_r;  letter_nxt = letter_r;  last_nxt = last_r;
    phase_nxt = phase_r;  cursor_nxt = cursor_r;  node_total_nxt = node_total_r;
    ovf_nxt = ovf_r;  head_nxt = head_r;  tail_nxt = tail_r;  i_nxt = i_r;
    c_nxt = c_r;  now_nxt = now_r;  fnow_nxt = fnow_r;  ch_nxt = ch_r;
    u_nxt = u_r;  v_nxt = v_r;  hu_nxt = hu_r;  clr_nxt = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cnt_nxt = out_cnt_r;  out_full_nxt = out_full_r;
    gt_we = 1'b0;  gt_waddr = '0;  gt_wdata = '0;  gt_re = 1'b0;  gt_raddr = '0;
    fl_we = 1'b0;  fl_waddr = '0;  fl_wdata = '0;  fl_re = 1'b0;  fl_raddr = '0;
    dg_we = 1'b0;  dg_waddr = '0;  dg_wdata = '0;  dg_re = 1'b0;  dg_raddr = '0;
    hc_we = 1'b0;  hc_waddr = '0;  hc_wdata = '0;  hc_re = 1'b0;  hc_raddr = '0;
    wq_we = 1'b0;  wq_waddr = '0;  wq_wdata = '0;  wq_re = 1'b0;  wq_raddr = '0;
    unique case (cmd.op)
      ac_pkg::OP_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          letter_nxt = in_letter;
          last_nxt = in_last;
        end
      end
      ac_pkg::OP_CLR: begin
        gt_we = 1'b1;
        gt_waddr = clr_r;
        if (clr_r < GW'(NODES)) begin
          fl_we = 1'b1;  fl_waddr = clr_r[NW-1:0];
          dg_we = 1'b1;  dg_waddr = clr_r[NW-1:0];
          hc_we = 1'b1;  hc_waddr = clr_r[NW-1:0];
        end
        clr_nxt = clr_r + 1'b1;
      end
      ac_pkg::OP_CHECK: begin
        head_nxt = '0;
        tail_nxt = '0;
        c_nxt = '0;
        i_nxt = QW'(1);
      end
      ac_pkg::OP_PHASE: begin
        phase_nxt = kind_r;
        cursor_nxt = '0;
      end
      ac_pkg::OP_STEP_RD: begin
        gt_re = 1'b1;
        gt_raddr = step_idx;
      end
      ac_pkg::OP_STEP_USE: begin
        if (phase_r == ac_pkg::KIND_INSERT) begin
          if (gt_rdata == '0) begin
            if (node_total_r < NW'(MAX_NODES)) begin
              gt_we = 1'b1;
              gt_waddr = step_idx;
              gt_wdata = node_total_r + 1'b1;
              node_total_nxt = node_total_r + 1'b1;
              cursor_nxt = node_total_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            cursor_nxt = gt_rdata;
          end
          if (last_r) begin
            cursor_nxt = '0;
          end
        end else begin
          cursor_nxt = last_r ? '0 : gt_rdata;
          hc_re = 1'b1;
          hc_raddr = gt_rdata;
          u_nxt = gt_rdata;
        end
      end
      ac_pkg::OP_SCAN_WR: begin
        hc_we = 1'b1;
        hc_waddr = u_r;
        hc_wdata = ac_pkg::sat_add(hc_rdata, 32'd1);
      end
      ac_pkg::OP_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt = (phase_r == ac_pkg::KIND_QUERY) ? hc_rdata : 32'd0;
          out_full_nxt = ovf_r;
        end
      end
      ac_pkg::OP_B_R0: begin
        gt_re = 1'b1;
        gt_raddr = GW'(c_r);
      end
      ac_pkg::OP_B_R0U: begin
        if (gt_rdata != '0 && can_push) begin
          wq_we = 1'b1;
          wq_waddr = tail_r[NW-1:0];
          wq_wdata = gt_rdata;
          tail_nxt = tail_r + 1'b1;
        end
        c_nxt = st.c_last ? '0 : c_r + 1'b1;
      end
      ac_pkg::OP_B_POP, ac_pkg::OP_P_POP: begin
        if (head_r == tail_r) begin
          head_nxt = '0;
          tail_nxt = '0;
          i_nxt = QW'(1);
        end else begin
          wq_re = 1'b1;
          wq_raddr = head_r[NW-1:0];
          head_nxt = head_r + 1'b1;
        end
      end
      ac_pkg::OP_B_NOW: begin
        now_nxt = wq_rdata;
        fl_re = 1'b1;
        fl_raddr = wq_rdata;
      end
      ac_pkg::OP_B_FNOW: begin
        fnow_nxt = fl_rdata;
      end
      ac_pkg::OP_B_RCH: begin
        gt_re = 1'b1;
        gt_raddr = gidx(now_r, c_r);
      end
      ac_pkg::OP_B_RVIA: begin
        ch_nxt = gt_rdata;
        gt_re = 1'b1;
        gt_raddr = gidx(fnow_r, c_r);
      end
      ac_pkg::OP_B_USE: begin
        if (ch_r != '0) begin
          fl_we = 1'b1;
          fl_waddr = ch_r;
          fl_wdata = gt_rdata;
          if (can_push) begin
            wq_we = 1'b1;
            wq_waddr = tail_r[NW-1:0];
            wq_wdata = ch_r;
            tail_nxt = tail_r + 1'b1;
          end
        end else begin
          gt_we = 1'b1;
          gt_waddr = gidx(now_r, c_r);
          gt_wdata = gt_rdata;
        end
        c_nxt = st.c_last ? '0 : c_r + 1'b1;
      end
      ac_pkg::OP_P_DEG_RD: begin
        if (st.i_over) begin
          i_nxt = QW'(1);
        end else begin
          fl_re = 1'b1;
          fl_raddr = i_r[NW-1:0];
        end
      end
      ac_pkg::OP_P_DEG_F: begin
        v_nxt = fl_rdata;
        dg_re = 1'b1;
        dg_raddr = fl_rdata;
      end
      ac_pkg::OP_P_DEG_W: begin
        dg_we = 1'b1;
        dg_waddr = v_r;
        dg_wdata = dg_rdata + 1'b1;
        i_nxt = i_r + 1'b1;
      end
      ac_pkg::OP_P_Z_RD: begin
        if (!st.i_over) begin
          dg_re = 1'b1;
          dg_raddr = i_r[NW-1:0];
        end
      end
      ac_pkg::OP_P_Z_U: begin
        if (dg_rdata == '0 && can_push) begin
          wq_we = 1'b1;
          wq_waddr = tail_r[NW-1:0];
          wq_wdata = i_r[NW-1:0];
          tail_nxt = tail_r + 1'b1;
        end
        i_nxt = i_r + 1'b1;
      end
      ac_pkg::OP_P_U: begin
        fl_re = 1'b1;
        fl_raddr = wq_rdata;
        hc_re = 1'b1;
        hc_raddr = wq_rdata;
      end
      ac_pkg::OP_P_V: begin
        v_nxt = fl_rdata;
        hu_nxt = hc_rdata;
        dg_re = 1'b1;
        dg_raddr = fl_rdata;
        hc_re = 1'b1;
        hc_raddr = fl_rdata;
      end
      ac_pkg::OP_P_UPD: begin
        dg_we = 1'b1;
        dg_waddr = v_r;
        dg_wdata = dnew;
        hc_we = 1'b1;
        hc_waddr = v_r;
        hc_wdata = ac_pkg::sat_add(hc_rdata, hu_r);
        if (v_r != '0 && dnew == '0 && can_push) begin
          wq_we = 1'b1;
          wq_waddr = tail_r[NW-1:0];
          wq_wdata = v_r;
          tail_nxt = tail_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ac_pkg::KIND_INSERT;
      cursor_r <= '0;
      node_total_r <= '0;
      ovf_r <= 1'b0;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      i_r <= '0;
      c_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      cursor_r <= cursor_nxt;
      node_total_r <= node_total_nxt;
      ovf_r <= ovf_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      i_r <= i_nxt;
      c_r <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    letter_r <= letter_nxt;
    last_r <= last_nxt;
    now_r <= now_nxt;
    fnow_r <= fnow_nxt;
    ch_r <= ch_nxt;
    u_r <= u_nxt;
    v_r <= v_nxt;
    hu_r <= hu_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_full_r <= out_full_nxt;
  end

  ac_ram #(.W(NW), .D(GD)) u_goto (
    .clk(clk), .we(gt_we), .waddr(gt_waddr), .wdata(gt_wdata),
    .re(gt_re), .raddr(gt_raddr), .rdata(gt_rdata)
  );

  ac_ram #(.W(NW), .D(NODES)) u_fail (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .re(fl_re), .raddr(fl_raddr), .rdata(fl_rdata)
  );

  ac_ram #(.W(NW), .D(NODES)) u_deg (
    .clk(clk), .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
    .re(dg_re), .raddr(dg_raddr), .rdata(dg_rdata)
  );

  ac_ram #(.W(32), .D(NODES)) u_hits (
    .clk(clk), .we(hc_we), .waddr(hc_waddr), .wdata(hc_wdata),
    .re(hc_re), .raddr(hc_raddr), .rdata(hc_rdata)
  );

  ac_ram #(.W(NW), .D(NODES)) u_queue (
    .clk(clk), .we(wq_we), .waddr(wq_waddr), .wdata(wq_wdata),
    .re(wq_re), .raddr(wq_raddr), .rdata(wq_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_match_count = out_cnt_r;
  assign out_trie_full   = out_full_r;

endmodule

[verif/aho_corasick_occurrence_counter_tb.sv]
// ----------------------------------------------------------------------------
// Aho-Corasick occurrence counter testbench
// Drives insert, scan and query words through one full pass of the block and
// checks every result word against a cycle-free model of the automaton that
// is kept inside the testbench. Both channels idle at random over the first two thirds of the words.
// ----------------------------------------------------------------------------
module aho_corasick_occurrence_counter_tb;

  localparam int MAX_NODES = 1024;
  localparam int ALPHABET  = 26;
  localparam int NODES     = MAX_NODES + 1;

  typedef struct {
    logic [1:0] kind;
    logic [4:0] letter;
    logic       last;
    logic       drain;
  } word_t;

  typedef struct {
    logic [31:0] match_count;
    logic        trie_full;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [4:0]  in_letter;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_match_count;
  logic        out_trie_full;

  aho_corasick_occurrence_counter #(
    .MAX_NODES(MAX_NODES),
    .ALPHABET (ALPHABET)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_letter      (in_letter),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match_count(out_match_count),
    .out_trie_full  (out_trie_full)
  );

  // Automaton state held by the testbench.
  logic [10:0] trans[NODES*ALPHABET];
  logic [10:0] fail_of[NODES];
  logic [10:0] fan_in[NODES];
  logic [31:0] hits[NODES];
  logic [10:0] node_cnt;
  logic [10:0] state_now;
  logic [1:0]  stage;
  logic        overflowed;

  word_t   words_q[$];
  answer_t answers_q[$];
  logic [4:0] pat_letters[$];
  int pat_start[$];
  int pat_len[$];

  int errors;
  int words_total;
  int words_sent;
  int results_seen;
  int send_gap;
  int recv_gap;
  word_t cur;
  logic fire;

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic build_failure_links();
    int order[NODES];
    int head;
    int tail;
    int now;
    int fnow;
    logic [10:0] ch;
    logic [10:0] via;
    head = 0;
    tail = 0;
    for (int c = 0; c < ALPHABET; c++) begin
      if (trans[c] != 0 && tail < NODES) begin
        order[tail] = trans[c];
        tail++;
      end
    end
    while (head < tail) begin
      now = order[head];
      head++;
      fnow = fail_of[now];
      for (int c = 0; c < ALPHABET; c++) begin
        ch  = trans[now*ALPHABET + c];
        via = trans[fnow*ALPHABET + c];
        if (ch != 0) begin
          fail_of[ch] = via;
          if (tail < NODES) begin
            order[tail] = ch;
            tail++;
          end
        end else begin
          trans[now*ALPHABET + c] = via;
        end
      end
    end
  endtask

  task automatic push_hits_up();
    int order[NODES];
    int head;
    int tail;
    int u;
    int v;
    head = 0;
    tail = 0;
    for (int i = 1; i <= node_cnt; i++) fan_in[fail_of[i]]++;
    for (int i = 1; i <= node_cnt; i++) begin
      if (fan_in[i] == 0 && tail < NODES) begin
        order[tail] = i;
        tail++;
      end
    end
    while (head < tail) begin
      u = order[head];
      head++;
      v = fail_of[u];
      if (fan_in[v] != 0) fan_in[v]--;
      hits[v] = add_sat(hits[v], hits[u]);
      if (v != 0 && fan_in[v] == 0 && tail < NODES) begin
        order[tail] = v;
        tail++;
      end
    end
  endtask

  task automatic count_step(input logic [1:0] kind, input logic [4:0] letter,
                            input logic last);
    int idx;
    answer_t a;
    if (kind > ac_pkg::KIND_QUERY || kind < stage || letter >= ALPHABET) return;
    if (kind > stage) begin
      if (stage == ac_pkg::KIND_INSERT) build_failure_links();
      if (kind == ac_pkg::KIND_QUERY) push_hits_up();
      stage = kind;
      state_now = 0;
    end
    if (state_now > MAX_NODES) state_now = 0;
    if (stage == ac_pkg::KIND_INSERT) begin
      idx = state_now*ALPHABET + letter;
      if (trans[idx] == 0) begin
        if (node_cnt < MAX_NODES) begin
          node_cnt++;
          trans[idx] = node_cnt;
          state_now = node_cnt;
        end else begin
          overflowed = 1'b1;
        end
      end else begin
        state_now = trans[idx];
      end
      if (last) begin
        state_now = 0;
        a.match_count = '0;
        a.trie_full = overflowed;
        answers_q.push_back(a);
      end
      return;
    end
    state_now = trans[state_now*ALPHABET + letter];
    if (state_now > MAX_NODES) state_now = 0;
    if (stage == ac_pkg::KIND_SCAN) begin
      hits[state_now] = add_sat(hits[state_now], 32'd1);
      if (last) state_now = 0;
      return;
    end
    if (last) begin
      a.match_count = hits[state_now];
      a.trie_full = overflowed;
      answers_q.push_back(a);
      state_now = 0;
    end
  endtask

  task automatic add_word(input logic [1:0] kind, input logic [4:0] letter,
                          input logic last, input logic drain = 1'b0);
    word_t w;
    w.kind = kind;
    w.letter = letter;
    w.last = last;
    w.drain = drain;
    words_q.push_back(w);
  endtask

  task automatic add_pattern(input logic [4:0] lets[$]);
    pat_start.push_back(pat_letters.size());
    pat_len.push_back(lets.size());
    foreach (lets[i]) begin
      pat_letters.push_back(lets[i]);
      add_word(ac_pkg::KIND_INSERT, lets[i], i == lets.size() - 1);
    end
  endtask

  task automatic add_noise(input logic [1:0] earlier);
    case ($urandom_range(2))
      0: add_word(2'd3, 5'($urandom_range(25)), 1'($urandom_range(1)));
      1: add_word(earlier, 5'($urandom_range(25)), 1'($urandom_range(1)));
      default: add_word(ac_pkg::KIND_QUERY, 5'($urandom_range(31, 26)),
                        1'($urandom_range(1)));
    endcase
  endtask

  task automatic make_stimulus();
    logic [4:0] p[$];
    int n;
    int len;
    int k;
    // Classic overlapping dictionary plus letter extremes.
    p = '{5'd7, 5'd4};                add_pattern(p);
    p = '{5'd18, 5'd7, 5'd4};         add_pattern(p);
    p = '{5'd7, 5'd8, 5'd18};         add_pattern(p);
    p = '{5'd7, 5'd4, 5'd17, 5'd18};  add_pattern(p);
    p = '{5'd0};                      add_pattern(p);
    p = '{5'd25, 5'd0, 5'd25};        add_pattern(p);
    add_word(ac_pkg::KIND_INSERT, 5'd31, 1'b0);
    add_word(ac_pkg::KIND_INSERT, 5'd26, 1'b1);
    add_word(2'd3, 5'd0, 1'b1);
    // Grow the trie from short words over a few letters and longer random words.
    n = 0;
    while (n < 500) begin
      p.delete();
      if ($urandom_range(1)) begin
        len = $urandom_range(5, 1);
        repeat (len) p.push_back(5'($urandom_range(3)));
      end else begin
        len = $urandom_range(14, 6);
        repeat (len) p.push_back(5'($urandom_range(25)));
      end
      add_pattern(p);
      n += len;
      if ($urandom_range(19) == 0) add_noise(2'd3);
    end
    // Text: the scan phase starts only after every insert answer is back.
    add_word(ac_pkg::KIND_SCAN, 5'd20, 1'b0, 1'b1);
    foreach (p[i]) p[i] = 0;
    p = '{5'd18, 5'd7, 5'd4, 5'd17, 5'd18, 5'd25, 5'd0, 5'd25};
    foreach (p[i]) add_word(ac_pkg::KIND_SCAN, p[i], 1'b0);
    add_word(ac_pkg::KIND_SCAN, 5'd0, 1'b1);
    repeat (200) begin
      if ($urandom_range(9) == 0) add_noise(ac_pkg::KIND_INSERT);
      add_word(ac_pkg::KIND_SCAN,
               $urandom_range(3) != 0 ? 5'($urandom_range(3)) : 5'($urandom_range(25)),
               $urandom_range(11) == 0);
    end
    // Queries: stored patterns, their prefixes and random strings.
    for (int q = 0; q < 50; q++) begin
      k = $urandom_range(pat_len.size() - 1);
      if (q < 6) k = q;
      case (q < 6 ? 0 : $urandom_range(4))
        0, 1, 2: len = pat_len[k];
        3: len = $urandom_range(pat_len[k], 1);
        default: len = 0;
      endcase
      if (len == 0) begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++)
          add_word(ac_pkg::KIND_QUERY, 5'($urandom_range(25)), i == len - 1,
                   q == 0 && i == 0);
      end else begin
        for (int i = 0; i < len; i++)
          add_word(ac_pkg::KIND_QUERY, pat_letters[pat_start[k] + i], i == len - 1,
                   q == 0 && i == 0);
      end
      if ($urandom_range(7) == 0) add_noise(2'($urandom_range(1)));
    end
  endtask

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_kind   <= '0;
      in_letter <= '0;
      in_last   <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        count_step(in_kind, in_letter, in_last);
        words_sent++;
      end
      if (words_sent * 3 < words_total) begin
        send_gap = 27;
        recv_gap = 71;
      end else if (words_sent * 3 < words_total * 2) begin
        send_gap = 71;
        recv_gap = 27;
      end else begin
        send_gap = 0;
        recv_gap = 0;
      end
      if (!in_valid || fire) begin
        if (words_q.size() > 0 && !(words_q[0].drain && answers_q.size() > 0) &&
            $urandom_range(99) >= send_gap) begin
          cur = words_q.pop_front();
          in_valid  <= 1'b1;
          in_kind   <= cur.kind;
          in_letter <= cur.letter;
          in_last   <= cur.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_gap;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (answers_q.size() == 0) begin
        $error("result word with no expectation: match_count %0d trie_full %0b",
               out_match_count, out_trie_full);
        errors++;
      end else begin
        if (out_match_count !== answers_q[0].match_count) begin
          $error("match_count expected %0d actual %0d",
                 answers_q[0].match_count, out_match_count);
          errors++;
        end
        if (out_trie_full !== answers_q[0].trie_full) begin
          $error("trie_full expected %0b actual %0b",
                 answers_q[0].trie_full, out_trie_full);
          errors++;
        end
        void'(answers_q.pop_front());
      end
    end
  end

  initial begin
    foreach (trans[i]) trans[i] = '0;
    foreach (fail_of[i]) begin
      fail_of[i] = '0;
      fan_in[i] = '0;
      hits[i] = '0;
    end
    node_cnt = '0;
    state_now = '0;
    stage = ac_pkg::KIND_INSERT;
    overflowed = 1'b0;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    send_gap = 27;
    recv_gap = 71;
    rst_n = 1'b0;
    make_stimulus();
    words_total = words_q.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (words_q.size() == 0 && !in_valid);
    wait (answers_q.size() == 0);
    repeat (50) @(posedge clk);
    if (answers_q.size() != 0) begin
      $error("%0d expected result words never arrived", answers_q.size());
      errors++;
    end
    $display("Sent %0d words through insert, scan and query; checked %0d results.",
             words_sent, results_seen);
    $display("Trie held %0d nodes, overflow reached: %0b.", node_cnt, overflowed);
    if (errors == 0) begin
      $display("aho_corasick_occurrence_counter_tb: clean");
    end else begin
      $display("aho_corasick_occurrence_counter_tb: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out waiting for the block.");
    $display("aho_corasick_occurrence_counter_tb: errors");
    $finish;
  end

endmodule
